>>> src/trb_ring_producer_core_defines.svh
// Assertion macros used by the ring producer core.
`ifndef TRB_RING_PRODUCER_CORE_DEFINES_SVH
`define TRB_RING_PRODUCER_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define TRB_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("trb_ring_producer_core: invariant broken");

// Consequent must hold in the same cycle as the antecedent.
`define TRB_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trb_ring_producer_core: implication broken");

`endif

>>> src/trb_pkg.sv
// Shared types and constants of the ring producer.
package trb_pkg;

    localparam int TRB_RING_DEPTH = 256;

    localparam int CFG_SIZE_W = 9;
    localparam logic [CFG_SIZE_W-1:0] CFG_SIZE_RESET = 9'd256;

    // Configuration register indexes
    localparam logic [0:0] CFG_RING_SIZE = 1'b0;
    localparam logic [0:0] CFG_RING_BASE = 1'b1;

    // Link descriptor control word: type in bits 15:10, toggle-cycle in bit 1
    localparam logic [31:0] LINK_TYPE  = 32'd6;
    localparam int          TYPE_SHIFT = 10;
    localparam logic [31:0] TOGGLE_BIT = 32'h0000_0002;
    localparam logic [31:0] LINK_CTL   = (LINK_TYPE << TYPE_SHIFT) | TOGGLE_BIT;

    typedef enum logic [1:0] {
        REQ_INIT      = 2'd0,
        REQ_ENQ_EXACT = 2'd1,
        REQ_ENQ_CYCLE = 2'd2
    } t_req;

    typedef enum logic {
        KIND_FULL = 1'b0,
        KIND_CTRL = 1'b1
    } t_kind;

endpackage

>>> src/trb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/trb_ring_producer_core.sv
// Top level of the descriptor ring producer with link descriptor and cycle bit.
// Producer side of a ring of 16-byte descriptors whose last slot holds a link
// back to the ring base. Each memory write the ring needs leaves as one output
// beat: an init request gives one full write of the link slot; an enqueue gives
// a full write of the enqueue slot and then one control-only write that sets
// the next slot's cycle bit to the inverse of the producer cycle bit, or, at
// the end of the ring, two control-only writes (link cycle stamp, then slot 0).
// The kept control words live in a single-port-write RAM with registered read,
// which the read-modify-write steps go through one at a time. An init passes
// S_FIRST, an enqueue S_FIRST and S_SECOND, a wrap also S_RD0 and S_THIRD; each
// beat waits while the output is held by backpressure. After reset the block
// sweeps the RAM to zero, one entry a cycle, over all RING_DEPTH entries before
// it takes the first beat; configuration writes are taken at all times.
`include "trb_ring_producer_core_defines.svh"

module trb_ring_producer_core
    import trb_pkg::*;
#(
    parameter int RING_DEPTH = TRB_RING_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [127:0]  i_s_tdata,   // param_low, param_high, status_word, control_word
    input  logic [1:0]    i_s_tuser,   // req_type
    // write stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [135:0]  o_m_tdata,   // slot, param_value, status_value, control_value
    output logic          o_m_tuser,   // write_kind
    output logic          o_m_tlast,   // last
    // configuration writes
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int SW    = (IDX_W + 1 > CFG_SIZE_W) ? IDX_W + 1 : CFG_SIZE_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_RD0,
        S_THIRD
    } t_state;

    t_state                  r_state;
    logic [IDX_W-1:0]        r_clr_addr;
    logic [CFG_SIZE_W-1:0]   r_ring_size;
    logic [63:0]             r_ring_base;
    logic [IDX_W-1:0]        r_enq_slot;
    logic                    r_cycle;
    logic                    r_ring_ready;

    // request held across the read-modify-write steps
    logic                    r_init;
    logic                    r_wrap;
    logic [IDX_W-1:0]        r_first_addr;
    logic [IDX_W-1:0]        r_target1;
    logic [63:0]             r_param;
    logic [31:0]             r_status;
    logic [31:0]             r_ctl;

    // output register
    logic                    r_out_valid;
    logic [7:0]              r_out_slot;
    t_kind                   r_out_kind;
    logic [63:0]             r_out_param;
    logic [31:0]             r_out_status;
    logic [31:0]             r_out_ctl;
    logic                    r_out_last;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [31:0]             ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [31:0]             ram_rdata;

    logic [SW-1:0]           size_ext;
    logic [SW-1:0]           size_used;
    logic [SW-1:0]           link_full;
    logic [IDX_W-1:0]        link_slot;
    logic [IDX_W-1:0]        enq_eff;
    logic [IDX_W-1:0]        nxt_slot;
    logic                    wrap;
    logic                    s_acc;
    logic                    out_free;
    logic                    out_load;
    logic [31:0]             mod_second;
    logic [31:0]             mod_third;

    function automatic logic [7:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [SW-1:0] ext;
        ext = SW'(idx);
        return ext[7:0];
    endfunction

    trb_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ctl_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Clamp the ring size to [2, RING_DEPTH] and place the enqueue slot in it.
    always_comb begin
        size_ext = SW'(r_ring_size);
        if (size_ext < SW'(2)) begin
            size_used = SW'(2);
        end else if (size_ext > SW'(RING_DEPTH)) begin
            size_used = SW'(RING_DEPTH);
        end else begin
            size_used = size_ext;
        end
        link_full = size_used - SW'(1);
        link_slot = link_full[IDX_W-1:0];
        enq_eff   = (SW'(r_enq_slot) >= link_full) ? '0 : r_enq_slot;
        nxt_slot  = enq_eff + IDX_W'(1);
        wrap      = (nxt_slot == link_slot);
    end

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    // load a new beat into the output register this cycle
    assign out_load   = out_free &&
                        (r_state == S_FIRST || r_state == S_SECOND || r_state == S_THIRD);
    assign mod_second = {ram_rdata[31:1], r_wrap ? r_cycle : ~r_cycle};
    assign mod_third  = {ram_rdata[31:1], ~r_cycle};

    // Hold the read address on the slot to be modified until its beat leaves.
    assign ram_raddr = (r_state == S_RD0 || r_state == S_THIRD) ? '0 : r_target1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_target1;
        ram_wdata = mod_second;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_FIRST: begin
                ram_we    = out_free;
                ram_waddr = r_first_addr;
                ram_wdata = r_ctl;
            end
            S_SECOND: begin
                ram_we    = out_free;
            end
            S_THIRD: begin
                ram_we    = out_free;
                ram_waddr = '0;
                ram_wdata = mod_third;
            end
            S_IDLE, S_RD0: begin
                ram_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_ring_size  <= CFG_SIZE_RESET;
            r_ring_base  <= '0;
            r_enq_slot   <= '0;
            r_cycle      <= 1'b1;
            r_ring_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RING_SIZE) begin
                    r_ring_size <= i_cfg_data[CFG_SIZE_W-1:0];
                end else begin
                    r_ring_base <= i_cfg_data;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + IDX_W'(1);
                    if (r_clr_addr == IDX_W'(RING_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_target1 <= wrap ? link_slot : nxt_slot;
                        r_wrap    <= wrap;
                        unique case (i_s_tuser)
                            REQ_INIT: begin
                                r_init       <= 1'b1;
                                r_first_addr <= link_slot;
                                r_ctl        <= LINK_CTL;
                                r_param      <= r_ring_base;
                                r_status     <= '0;
                                r_enq_slot   <= '0;
                                r_cycle      <= 1'b1;
                                r_ring_ready <= 1'b1;
                                r_state      <= S_FIRST;
                            end
                            REQ_ENQ_EXACT, REQ_ENQ_CYCLE: begin
                                r_init       <= 1'b0;
                                r_first_addr <= enq_eff;
                                r_param      <= i_s_tdata[63:0];
                                r_status     <= i_s_tdata[95:64];
                                r_ctl        <= (i_s_tuser == REQ_ENQ_CYCLE)
                                                ? {i_s_tdata[127:97], r_cycle}
                                                : i_s_tdata[127:96];
                                // drop enqueues until the ring is initialized
                                if (r_ring_ready) begin
                                    r_state <= S_FIRST;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FIRST: begin
                    if (out_free) begin
                        r_out_slot   <= to_slot(r_first_addr);
                        r_out_kind   <= KIND_FULL;
                        r_out_param  <= r_param;
                        r_out_status <= r_status;
                        r_out_ctl    <= r_ctl;
                        r_out_last   <= r_init;
                        r_state      <= r_init ? S_IDLE : S_SECOND;
                    end
                end
                S_SECOND: begin
                    if (out_free) begin
                        r_out_slot   <= to_slot(r_target1);
                        r_out_kind   <= KIND_CTRL;
                        r_out_param  <= '0;
                        r_out_status <= '0;
                        r_out_ctl    <= mod_second;
                        r_out_last   <= !r_wrap;
                        if (r_wrap) begin
                            r_enq_slot <= '0;
                            r_cycle    <= ~r_cycle;
                            r_state    <= S_RD0;
                        end else begin
                            r_enq_slot <= r_target1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_THIRD;
                end
                S_THIRD: begin
                    if (out_free) begin
                        r_out_slot   <= '0;
                        r_out_kind   <= KIND_CTRL;
                        r_out_param  <= '0;
                        r_out_status <= '0;
                        r_out_ctl    <= mod_third;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_ctl, r_out_status, r_out_param, r_out_slot};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    `TRB_ASSERT_HOLDS(a_enq_below_link, r_enq_slot <= IDX_W'(RING_DEPTH - 2))
    `TRB_ASSERT_IMPLIES(a_rmw_apart, (r_state == S_SECOND) && !r_init, r_target1 != r_first_addr)
    `TRB_ASSERT_IMPLIES(a_idle_no_write, r_state == S_IDLE, !ram_we)
    `TRB_ASSERT_IMPLIES(a_third_on_wrap, (r_state == S_RD0) || (r_state == S_THIRD), r_wrap)

endmodule
